// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, codes and the CRC-32C byte update for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [3:0] status_t;
  typedef logic [1:0] cfg_index_t;

  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_END     = 2'd2;
  localparam kind_t KIND_ERROR   = 2'd3;

  localparam status_t ST_OK          = 4'd0;
  localparam status_t ST_MAGIC       = 4'd1;
  localparam status_t ST_HEADER_CRC  = 4'd2;
  localparam status_t ST_VERSION     = 4'd3;
  localparam status_t ST_TYPE        = 4'd4;
  localparam status_t ST_FLAGS       = 4'd5;
  localparam status_t ST_RESERVED    = 4'd6;
  localparam status_t ST_TOO_LONG    = 4'd7;
  localparam status_t ST_PAYLOAD_CRC = 4'd8;

  localparam cfg_index_t CFG_EXPECTED_VERSION = 2'd0;
  localparam cfg_index_t CFG_LENGTH_LIMIT     = 2'd1;
  localparam cfg_index_t CFG_VALID_TYPE_MASK  = 2'd2;

  // Byte positions at which a header field is complete, and other header/trailer bounds.
  localparam int HDR_MAGIC_BYTES  = 4;
  localparam int HDR_VERSION_END  = 5;
  localparam int HDR_TYPE_END     = 7;
  localparam int HDR_FLAGS_END    = 9;
  localparam int HDR_RESERVED_END = 11;
  localparam int HDR_LENGTH_END   = 15;
  localparam int HDR_COVERED      = 16;
  localparam int HDR_LAST         = 19;
  localparam int TRAILER_LAST     = 3;

  localparam logic [7:0] FRAME_MAGIC [4] = '{8'h44, 8'h4D, 8'h46, 8'h46};

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    SEC_HEADER  = 3'b001,
    SEC_PAYLOAD = 3'b010,
    SEC_TRAILER = 3'b100
  } section_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] message_type;
    logic [16:0] frame_length;
    status_t     status;
  } result_t;

  // Reflected CRC-32C update by one byte, bit by bit.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                              input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc_checked_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Parses length-prefixed frames with CRC-32C checked header and payload.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  byte     in         byte_valid / byte_stall   command, data_byte
//  result   out        result_valid / result_stall
//                                                kind, payload_byte,
//                                                message_type, frame_length,
//                                                status
//  cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The CRC byte update, field capture and header checks settle between the parse
// registers and the result register, so an item's result is offered on the cycle
// after it is taken unless the result is stalled. A one-item skid
// register behind the result register lets items keep flowing while a result
// waits; byte_stall rises only while the skid register is occupied. Reset is
// synchronous, restores the registers and starts the parser on a new header.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_deframer #(
  parameter int LENGTH_CAP = 65536
) (
  input  wire                      clk,
  input  wire                      rst,
  // Byte input channel.
  input  wire                      byte_valid,
  output logic                     byte_stall,
  input  wire                      command,
  input  wire  [7:0]               data_byte,
  // Result channel.
  output logic                     result_valid,
  input  wire                      result_stall,
  output cfd_pkg::kind_t           kind,
  output logic [7:0]               payload_byte,
  output logic [15:0]              message_type,
  output logic [16:0]              frame_length,
  output cfd_pkg::status_t         status,
  // Configuration write channel.
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  cfd_pkg::cfg_index_t cfg_index,
  input  wire  [63:0]              cfg_data
);

  import cfd_pkg::*;

`include "assert_macros.svh"

  // The position counter covers both the header bytes and the longest payload.
  localparam int LEN_W = $clog2(LENGTH_CAP + 1);
  localparam int POS_W = (LEN_W > 5) ? LEN_W : 5;
  localparam logic [31:0] MAX_LEN = 32'(LENGTH_CAP);

  // Configuration registers.
  logic [15:0] expected_version;
  logic [23:0] length_limit;
  logic [63:0] valid_type_mask;

  // Parse state.
  section_t       section, section_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]    running_crc, running_crc_next;
  logic [31:0]    header_crc_result, header_crc_result_next;
  logic [31:0]    field_shift, field_shift_next;
  logic           magic_matched, magic_matched_next;
  logic [15:0]    version_seen, version_seen_next;
  logic [15:0]    type_seen, type_seen_next;
  logic           flags_zero, flags_zero_next;
  logic           reserved_zero, reserved_zero_next;
  logic [31:0]    length_seen, length_seen_next;
  status_t        sticky_error, sticky_error_next;

  // Result register and its skid register.
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  result_t res;
  logic    res_valid;
  logic    byte_accept;
  logic    out_free;
  logic    [31:0] payload_bound;
  status_t hdr_status;

  assign cfg_ready   = 1'b1;
  assign byte_stall  = skid_valid;
  assign byte_accept = byte_valid && !byte_stall;
  assign out_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 16'd1;
      length_limit     <= 24'd0;
      valid_type_mask  <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_VERSION: expected_version <= cfg_data[15:0];
        CFG_LENGTH_LIMIT:     length_limit     <= cfg_data[23:0];
        CFG_VALID_TYPE_MASK:  valid_type_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero bound, or one above the build limit, means the build limit.
  assign payload_bound = (length_limit == 24'd0 || {8'd0, length_limit} > MAX_LEN) ?
                         MAX_LEN : {8'd0, length_limit};

  // Header checks in priority order; the first failure names the status.
  // The header CRC is compared against the trailing field as it completes.
  always_comb begin
    logic [31:0] fs_last;
    fs_last = {data_byte, field_shift[31:8]};
    if (!magic_matched) begin
      hdr_status = ST_MAGIC;
    end else if (header_crc_result != fs_last) begin
      hdr_status = ST_HEADER_CRC;
    end else if (version_seen != expected_version) begin
      hdr_status = ST_VERSION;
    end else if (type_seen[15:6] != 10'd0 || !valid_type_mask[type_seen[5:0]]) begin
      hdr_status = ST_TYPE;
    end else if (!flags_zero) begin
      hdr_status = ST_FLAGS;
    end else if (!reserved_zero) begin
      hdr_status = ST_RESERVED;
    end else if (length_seen > payload_bound) begin
      hdr_status = ST_TOO_LONG;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    logic [31:0]      fs_shifted;
    logic [31:0]      crc_upd;
    logic [POS_W-1:0] pos_inc;

    fs_shifted = {data_byte, field_shift[31:8]};
    crc_upd    = crc32c_byte(running_crc, data_byte);
    pos_inc    = byte_position + POS_W'(1);

    section_next           = section;
    byte_position_next     = byte_position;
    running_crc_next       = running_crc;
    header_crc_result_next = header_crc_result;
    field_shift_next       = field_shift;
    magic_matched_next     = magic_matched;
    version_seen_next      = version_seen;
    type_seen_next         = type_seen;
    flags_zero_next        = flags_zero;
    reserved_zero_next     = reserved_zero;
    length_seen_next       = length_seen;
    sticky_error_next      = sticky_error;

    // Header fields of the result always come from the frame in progress.
    res_valid          = 1'b0;
    res.kind           = KIND_HEADER;
    res.payload_byte   = 8'd0;
    res.message_type   = type_seen;
    res.frame_length   = length_seen[16:0];
    res.status         = ST_OK;

    if (byte_accept) begin
      if (command) begin
        // Clear: back to the start of a header, error released.
        sticky_error_next      = ST_OK;
        section_next           = SEC_HEADER;
        byte_position_next     = '0;
        running_crc_next       = CRC_INIT;
        header_crc_result_next = 32'd0;
        field_shift_next       = 32'd0;
        magic_matched_next     = 1'b1;
        version_seen_next      = 16'd0;
        type_seen_next         = 16'd0;
        flags_zero_next        = 1'b1;
        reserved_zero_next     = 1'b1;
        length_seen_next       = 32'd0;
      end else if (sticky_error == ST_OK) begin
        case (section)
          SEC_PAYLOAD: begin
            running_crc_next = crc_upd;
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = data_byte;
            byte_position_next = pos_inc;
            if (32'(pos_inc) >= length_seen) begin
              section_next       = SEC_TRAILER;
              byte_position_next = '0;
              field_shift_next   = 32'd0;
            end
          end
          SEC_TRAILER: begin
            field_shift_next   = fs_shifted;
            byte_position_next = pos_inc;
            if (byte_position == POS_W'(TRAILER_LAST)) begin
              res_valid = 1'b1;
              if (fs_shifted != ~running_crc) begin
                sticky_error_next = ST_PAYLOAD_CRC;
                res.kind          = KIND_ERROR;
                res.status        = ST_PAYLOAD_CRC;
              end else begin
                res.kind               = KIND_END;
                section_next           = SEC_HEADER;
                byte_position_next     = '0;
                running_crc_next       = CRC_INIT;
                header_crc_result_next = 32'd0;
                field_shift_next       = 32'd0;
                magic_matched_next     = 1'b1;
                version_seen_next      = 16'd0;
                type_seen_next         = 16'd0;
                flags_zero_next        = 1'b1;
                reserved_zero_next     = 1'b1;
                length_seen_next       = 32'd0;
              end
            end
          end
          default: begin
            // Header section; an unused code behaves the same way.
            field_shift_next = fs_shifted;
            if (byte_position < POS_W'(HDR_COVERED)) begin
              running_crc_next = crc_upd;
            end
            if (byte_position < POS_W'(HDR_MAGIC_BYTES) &&
                data_byte != FRAME_MAGIC[byte_position[1:0]]) begin
              magic_matched_next = 1'b0;
            end
            case (byte_position)
              POS_W'(HDR_VERSION_END):  version_seen_next  = fs_shifted[31:16];
              POS_W'(HDR_TYPE_END):     type_seen_next     = fs_shifted[31:16];
              POS_W'(HDR_FLAGS_END):    flags_zero_next    = fs_shifted[31:16] == 16'd0;
              POS_W'(HDR_RESERVED_END): reserved_zero_next = fs_shifted[31:16] == 16'd0;
              POS_W'(HDR_LENGTH_END): begin
                length_seen_next       = fs_shifted;
                header_crc_result_next = ~crc_upd;
              end
              default: ;
            endcase
            if (byte_position != POS_W'(HDR_LAST)) begin
              byte_position_next = pos_inc;
            end else begin
              res_valid = 1'b1;
              if (hdr_status != ST_OK) begin
                sticky_error_next = hdr_status;
                res.kind          = KIND_ERROR;
                res.status        = hdr_status;
              end else begin
                res.kind           = KIND_HEADER;
                running_crc_next   = CRC_INIT;
                byte_position_next = '0;
                field_shift_next   = 32'd0;
                section_next       = (length_seen != 32'd0) ? SEC_PAYLOAD : SEC_TRAILER;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section           <= SEC_HEADER;
      byte_position     <= '0;
      running_crc       <= CRC_INIT;
      header_crc_result <= 32'd0;
      field_shift       <= 32'd0;
      magic_matched     <= 1'b1;
      version_seen      <= 16'd0;
      type_seen         <= 16'd0;
      flags_zero        <= 1'b1;
      reserved_zero     <= 1'b1;
      length_seen       <= 32'd0;
      sticky_error      <= ST_OK;
    end else begin
      section           <= section_next;
      byte_position     <= byte_position_next;
      running_crc       <= running_crc_next;
      header_crc_result <= header_crc_result_next;
      field_shift       <= field_shift_next;
      magic_matched     <= magic_matched_next;
      version_seen      <= version_seen_next;
      type_seen         <= type_seen_next;
      flags_zero        <= flags_zero_next;
      reserved_zero     <= reserved_zero_next;
      length_seen       <= length_seen_next;
      sticky_error      <= sticky_error_next;
    end
  end

  // The result register refills from the skid register first, so order holds.
  // A new result only lands in the skid register when the result is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign kind           = out_data.kind;
  assign payload_byte   = out_data.payload_byte;
  assign message_type   = out_data.message_type;
  assign frame_length   = out_data.frame_length;
  assign status         = out_data.status;

  // The skid register only holds an item behind a waiting result.
  `ASSERT_IMPLIES(a_skid_behind_result, clk, rst, skid_valid, result_valid)
  // Only error results carry a nonzero status.
  `ASSERT_IMPLIES(a_status_only_on_error, clk, rst,
                  result_valid && kind != KIND_ERROR, status == ST_OK)
  // While an error is held, data bytes cause no result.
  `ASSERT_IMPLIES(a_sticky_silent, clk, rst,
                  byte_accept && !command && sticky_error != ST_OK, !res_valid)
  // Inside the payload the position stays below the declared length.
  `ASSERT_IMPLIES(a_payload_position, clk, rst,
                  section == SEC_PAYLOAD, 32'(byte_position) < length_seen)
  // A stalled result with a full skid register keeps the input stalled.
  `ASSERT_NEXT(a_stall_holds, clk, rst,
               skid_valid && result_valid && result_stall, byte_stall)

endmodule

`default_nettype wire
